FILE: hdl/c1dvm_pkg.sv
// ----------------------------------------------------------------------------
// c1dvm_pkg
// Shared constants, codes and types of the multichannel 1D convolution block.
// ----------------------------------------------------------------------------
package c1dvm_pkg;

  localparam int DEF_MAX_TAPS         = 16;
  localparam int DEF_MAX_IN_CHANNELS  = 8;
  localparam int DEF_MAX_OUT_CHANNELS = 16;
  localparam int DEF_SAMPLE_WIDTH     = 16;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;
  localparam int CFG_TAPS_W = 5;
  localparam int CFG_ICS_W  = 4;
  localparam int CFG_OCS_W  = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_TAPS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IN_CHANNELS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_CHANNELS   = 2'd2;

  localparam logic REQ_WEIGHT = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  localparam int TAP_FIELD_W = 4;
  localparam int WIC_FIELD_W = 3;
  localparam int WOC_FIELD_W = 4;
  localparam int OUT_CH_W    = 4;
  localparam int RES_W       = 39;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MAC,
    ST_PUSH
  } state_t;

endpackage

FILE: hdl/c1dvm_ram.sv
// ----------------------------------------------------------------------------
// c1dvm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module c1dvm_ram #(
  parameter  int WIDTH = 16,
  parameter  int DEPTH = 128,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/conv1d_valid_multichannel.sv
// ----------------------------------------------------------------------------
// conv1d_valid_multichannel
// Multichannel 1D convolution, valid padding, Q8.8 in and Q23.16 out.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall): weight beats (req_type 0) write one
// kernel entry at (tap, input channel, output channel); sample beats
// (req_type 1) bring one channel value of the current time step.
// When a step completes with at least filter_taps steps in the sequence, the
// block runs one multiply-accumulate per (tap, input channel) for each output
// channel and emits one result beat per output channel, last set on the final
// one. Input is stalled during the run.
// Each output channel runs filter_taps * input_channel_count products through
// the shared multiplier and its memory read, product and accumulate registers.
// A run is set by the one read port of the window and kernel memories.
// After reset the window memory is swept to zero, one entry a cycle, over all
// MAX_TAPS * MAX_IN_CHANNELS entries (128 by default) with input stalled;
// configuration writes are taken during the sweep. The kernel memory holds
// nothing defined until written. While out_stall is high the result beat
// holds and the run waits before loading the next result.
// ----------------------------------------------------------------------------
module conv1d_valid_multichannel #(
  parameter int MAX_TAPS         = c1dvm_pkg::DEF_MAX_TAPS,
  parameter int MAX_IN_CHANNELS  = c1dvm_pkg::DEF_MAX_IN_CHANNELS,
  parameter int MAX_OUT_CHANNELS = c1dvm_pkg::DEF_MAX_OUT_CHANNELS,
  parameter int SAMPLE_WIDTH     = c1dvm_pkg::DEF_SAMPLE_WIDTH
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [c1dvm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [c1dvm_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_req_type,
  input  logic [c1dvm_pkg::TAP_FIELD_W-1:0]    in_weight_tap,
  input  logic [c1dvm_pkg::WIC_FIELD_W-1:0]    in_weight_in_channel,
  input  logic [c1dvm_pkg::WOC_FIELD_W-1:0]    in_weight_out_channel,
  input  logic signed [SAMPLE_WIDTH-1:0]       in_value,
  input  logic                                 in_sequence_start,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [c1dvm_pkg::OUT_CH_W-1:0]       out_channel,
  output logic signed [c1dvm_pkg::RES_W-1:0]   out_result_value,
  output logic                                 out_last
);

  import c1dvm_pkg::*;

  localparam int TAP_IW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int IC_IW  = (MAX_IN_CHANNELS > 1) ? $clog2(MAX_IN_CHANNELS) : 1;
  localparam int OC_IW  = (MAX_OUT_CHANNELS > 1) ? $clog2(MAX_OUT_CHANNELS) : 1;
  localparam int TAP_CW = $clog2(MAX_TAPS + 1);
  localparam int IC_CW  = $clog2(MAX_IN_CHANNELS + 1);
  localparam int OC_CW  = $clog2(MAX_OUT_CHANNELS + 1);
  localparam int KDEPTH = MAX_TAPS * MAX_IN_CHANNELS * MAX_OUT_CHANNELS;
  localparam int KAW    = (KDEPTH > 1) ? $clog2(KDEPTH) : 1;
  localparam int WDEPTH = MAX_TAPS * MAX_IN_CHANNELS;
  localparam int WAW    = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
  localparam int CLR_W  = $clog2(WDEPTH + 1);
  localparam int PROD_W = 2 * SAMPLE_WIDTH;

  state_t st_r, st_nxt;

  logic [CFG_TAPS_W-1:0] cfg_taps_r;
  logic [CFG_ICS_W-1:0]  cfg_ics_r;
  logic [CFG_OCS_W-1:0]  cfg_ocs_r;
  logic [TAP_CW-1:0]     taps_cnt;
  logic [IC_CW-1:0]      ics_cnt;
  logic [OC_CW-1:0]      ocs_cnt;

  logic [TAP_IW-1:0] ring_r;
  logic [IC_IW-1:0]  pos_r;
  logic [TAP_CW-1:0] filled_r;
  logic [CLR_W-1:0]  clr_cnt_r;
  logic [OC_IW-1:0]  oc_r;
  logic [TAP_IW-1:0] t_r;
  logic [IC_IW-1:0]  ic_r;
  logic [TAP_IW-1:0] slot_r;
  logic [TAP_IW-1:0] base_slot_r;

  logic in_acc, w_acc, s_acc, w_in_range;
  logic [IC_IW-1:0]  pos_eff;
  logic [TAP_CW-1:0] filled_eff, filled_inc;
  logic [TAP_IW-1:0] ring_inc, slot_inc, start_slot;
  logic step_end, run_start;
  logic ic_last, t_last, oc_last, iss_last;
  logic clr_we, iss_v, push;

  logic            k_we, w_we;
  logic [KAW-1:0]  k_waddr, k_raddr;
  logic [WAW-1:0]  w_waddr, w_raddr;
  logic [SAMPLE_WIDTH-1:0] w_wdata;
  logic signed [SAMPLE_WIDTH-1:0] win_rd, ker_rd;

  logic s1_v_r, s1_first_r, s1_last_r;
  logic s2_v_r, s2_first_r, s2_last_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [RES_W-1:0]  acc_r;
  logic acc_done_r;

  logic                       out_valid_r;
  logic [OUT_CH_W-1:0]        out_channel_r;
  logic signed [RES_W-1:0]    out_value_r;
  logic                       out_last_r;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_taps_r <= CFG_TAPS_W'(1);
      cfg_ics_r  <= CFG_ICS_W'(1);
      cfg_ocs_r  <= CFG_OCS_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FILTER_TAPS:  cfg_taps_r <= cfg_data[CFG_TAPS_W-1:0];
        CFG_IN_CHANNELS:  cfg_ics_r  <= cfg_data[CFG_ICS_W-1:0];
        CFG_OUT_CHANNELS: cfg_ocs_r  <= cfg_data[CFG_OCS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (cfg_taps_r == '0) taps_cnt = TAP_CW'(1);
    else if (32'(cfg_taps_r) > MAX_TAPS) taps_cnt = TAP_CW'(MAX_TAPS);
    else taps_cnt = TAP_CW'(cfg_taps_r);
    if (cfg_ics_r == '0) ics_cnt = IC_CW'(1);
    else if (32'(cfg_ics_r) > MAX_IN_CHANNELS) ics_cnt = IC_CW'(MAX_IN_CHANNELS);
    else ics_cnt = IC_CW'(cfg_ics_r);
    if (cfg_ocs_r == '0) ocs_cnt = OC_CW'(1);
    else if (32'(cfg_ocs_r) > MAX_OUT_CHANNELS) ocs_cnt = OC_CW'(MAX_OUT_CHANNELS);
    else ocs_cnt = OC_CW'(cfg_ocs_r);
  end

  // sample bookkeeping
  always_comb begin
    in_acc     = in_valid && !in_stall;
    w_acc      = in_acc && (in_req_type == REQ_WEIGHT);
    s_acc      = in_acc && (in_req_type == REQ_SAMPLE);
    w_in_range = (32'(in_weight_tap) < MAX_TAPS) &&
                 (32'(in_weight_in_channel) < MAX_IN_CHANNELS) &&
                 (32'(in_weight_out_channel) < MAX_OUT_CHANNELS);
    pos_eff    = in_sequence_start ? '0 : pos_r;
    filled_eff = in_sequence_start ? '0 : filled_r;
    step_end   = (32'(pos_eff) + 32'd1) >= 32'(ics_cnt);
    ring_inc   = (32'(ring_r) == MAX_TAPS - 1) ? '0 : ring_r + 1'b1;
    filled_inc = (32'(filled_eff) < MAX_TAPS) ? filled_eff + 1'b1 : filled_eff;
    run_start  = step_end && (filled_inc >= taps_cnt);
    if (32'(ring_inc) >= 32'(taps_cnt))
      start_slot = TAP_IW'(32'(ring_inc) - 32'(taps_cnt));
    else
      start_slot = TAP_IW'(32'(ring_inc) + MAX_TAPS - 32'(taps_cnt));
    slot_inc   = (32'(slot_r) == MAX_TAPS - 1) ? '0 : slot_r + 1'b1;
    ic_last    = (32'(ic_r) + 32'd1) == 32'(ics_cnt);
    t_last     = (32'(t_r) + 32'd1) == 32'(taps_cnt);
    oc_last    = (32'(oc_r) + 32'd1) == 32'(ocs_cnt);
    iss_last   = ic_last && t_last;
  end

  // state machine
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_CLEAR;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_CLEAR: if (32'(clr_cnt_r) == WDEPTH - 1) st_nxt = ST_IDLE;
      ST_IDLE:  if (s_acc && run_start) st_nxt = ST_MAC;
      ST_MAC:   if (iss_last) st_nxt = ST_PUSH;
      ST_PUSH: begin
        if (push) st_nxt = oc_last ? ST_IDLE : ST_MAC;
      end
      default:  st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    clr_we   = 1'b0;
    iss_v    = 1'b0;
    push     = 1'b0;
    unique case (st_r)
      ST_CLEAR: clr_we = 1'b1;
      ST_IDLE:  in_stall = 1'b0;
      ST_MAC:   iss_v = 1'b1;
      ST_PUSH:  push = acc_done_r && (!out_valid_r || !out_stall);
      default: ;
    endcase
  end

  // counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      ring_r      <= '0;
      pos_r       <= '0;
      filled_r    <= '0;
      oc_r        <= '0;
      t_r         <= '0;
      ic_r        <= '0;
      slot_r      <= '0;
      base_slot_r <= '0;
    end else begin
      if (clr_we) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (s_acc) begin
        if (step_end) begin
          pos_r    <= '0;
          ring_r   <= ring_inc;
          filled_r <= filled_inc;
        end else begin
          pos_r    <= pos_eff + 1'b1;
          filled_r <= filled_eff;
        end
        if (run_start) begin
          oc_r        <= '0;
          t_r         <= '0;
          ic_r        <= '0;
          slot_r      <= start_slot;
          base_slot_r <= start_slot;
        end
      end
      if (iss_v) begin
        if (ic_last) begin
          ic_r <= '0;
          if (!t_last) begin
            t_r    <= t_r + 1'b1;
            slot_r <= slot_inc;
          end
        end else begin
          ic_r <= ic_r + 1'b1;
        end
      end
      if (push && !oc_last) begin
        oc_r   <= oc_r + 1'b1;
        t_r    <= '0;
        ic_r   <= '0;
        slot_r <= base_slot_r;
      end
    end
  end

  // memories
  always_comb begin
    k_we    = w_acc && w_in_range;
    k_waddr = KAW'((32'(in_weight_tap) * MAX_IN_CHANNELS + 32'(in_weight_in_channel))
                   * MAX_OUT_CHANNELS + 32'(in_weight_out_channel));
    k_raddr = KAW'((32'(t_r) * MAX_IN_CHANNELS + 32'(ic_r)) * MAX_OUT_CHANNELS + 32'(oc_r));
    w_we    = clr_we || s_acc;
    w_waddr = clr_we ? clr_cnt_r[WAW-1:0]
                     : WAW'(32'(ring_r) * MAX_IN_CHANNELS + 32'(pos_eff));
    w_wdata = clr_we ? '0 : in_value;
    w_raddr = WAW'(32'(slot_r) * MAX_IN_CHANNELS + 32'(ic_r));
  end

  c1dvm_ram #(
    .WIDTH (SAMPLE_WIDTH),
    .DEPTH (KDEPTH)
  ) u_kernel_ram (
    .clk   (clk),
    .we    (k_we),
    .waddr (k_waddr),
    .wdata (in_value),
    .raddr (k_raddr),
    .rdata (ker_rd)
  );

  c1dvm_ram #(
    .WIDTH (SAMPLE_WIDTH),
    .DEPTH (WDEPTH)
  ) u_window_ram (
    .clk   (clk),
    .we    (w_we),
    .waddr (w_waddr),
    .wdata (w_wdata),
    .raddr (w_raddr),
    .rdata (win_rd)
  );

  // multiply-accumulate pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r     <= 1'b0;
      s2_v_r     <= 1'b0;
      acc_done_r <= 1'b0;
    end else begin
      s1_v_r <= iss_v;
      s2_v_r <= s1_v_r;
      if (s2_v_r && s2_last_r) begin
        acc_done_r <= 1'b1;
      end else if (push) begin
        acc_done_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_first_r <= (t_r == '0) && (ic_r == '0);
    s1_last_r  <= iss_last;
    s2_first_r <= s1_first_r;
    s2_last_r  <= s1_last_r;
    prod_r     <= win_rd * ker_rd;
    if (s2_v_r) begin
      acc_r <= s2_first_r ? RES_W'(prod_r) : acc_r + RES_W'(prod_r);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_channel_r <= OUT_CH_W'(oc_r);
      out_value_r   <= acc_r;
      out_last_r    <= oc_last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_channel      = out_channel_r;
  assign out_result_value = out_value_r;
  assign out_last         = out_last_r;

endmodule

FILE: hdl/c1dvm_checker.sv
// ----------------------------------------------------------------------------
// c1dvm_checker
// Port-level checks on the result channel of the convolution block.
// ----------------------------------------------------------------------------
module c1dvm_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_stall,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic [c1dvm_pkg::OUT_CH_W-1:0]     out_channel,
  input logic signed [c1dvm_pkg::RES_W-1:0] out_result_value,
  input logic                               out_last
);

  import c1dvm_pkg::*;

  logic [OUT_CH_W-1:0] exp_ch_r;

  // track the channel the next result beat should carry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_ch_r <= '0;
    end else if (out_valid && !out_stall) begin
      exp_ch_r <= out_last ? '0 : out_channel + 1'b1;
    end
  end

  a_reset_clears_output: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat present after reset");

  a_stalled_beat_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_channel) &&
      $stable(out_result_value) && $stable(out_last)))
    else $error("stalled result beat changed");

  a_channel_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_channel == exp_ch_r))
    else $error("result channel out of order");

  a_run_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> in_stall)
    else $error("input taken in the middle of a run");

endmodule

bind conv1d_valid_multichannel c1dvm_checker u_c1dvm_checker (.*);

FILE: tb/conv1d_valid_multichannel_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// conv1d_valid_multichannel_tb
// Self-checking bench for the multichannel valid-padding 1D convolution.
// ----------------------------------------------------------------------------
// Weight and sample beats go in through the valid/stall input channel. Every
// accepted beat also goes through a behavioural convolution kept in the
// bench. That model holds its own kernel, window ring and step counters, and
// queues the result beats that the beat should cause. Each accepted result
// beat is compared field by field with the oldest queued one.
// A short table of directed beats and register writes comes first. It covers
// the value extremes, the register clamps, a channel count lowered part way
// through a step and restarts of a sequence. Phases of random beats follow,
// each under its own register setting and pattern of sender and receiver
// idling. Kernel entries that a setting reads are always loaded first.
// ----------------------------------------------------------------------------
module conv1d_valid_multichannel_tb;
  import c1dvm_pkg::*;

  localparam int TAPS_MAX     = DEF_MAX_TAPS;
  localparam int ICH_MAX      = DEF_MAX_IN_CHANNELS;
  localparam int OCH_MAX      = DEF_MAX_OUT_CHANNELS;
  localparam int VAL_W        = DEF_SAMPLE_WIDTH;
  localparam int KRN_DEPTH    = TAPS_MAX * ICH_MAX * OCH_MAX;
  localparam int WIN_DEPTH    = TAPS_MAX * ICH_MAX;
  localparam int QUIET_CYCLES = 16;
  localparam int DRAIN_CYCLES = 3000;
  localparam int N_PHASES     = 10;

  typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;
  typedef enum {ROW_BEAT, ROW_REG} row_kind_e;

  typedef struct {
    logic                    req_type;
    logic [TAP_FIELD_W-1:0]  tap;
    logic [WIC_FIELD_W-1:0]  wic;
    logic [WOC_FIELD_W-1:0]  woc;
    logic signed [VAL_W-1:0] value;
    logic                    start;
  } beat_t;

  typedef struct {
    logic [OUT_CH_W-1:0]     channel;
    logic signed [RES_W-1:0] total;
    logic                    last;
  } conv_out_t;

  typedef struct {
    row_kind_e               kind;
    beat_t                   beat;
    logic [CFG_IDX_W-1:0]    reg_idx;
    logic [CFG_DATA_W-1:0]   reg_val;
    bit                      has_total;
    logic signed [RES_W-1:0] total;
  } dir_row_t;

  logic                       clk                  = 1'b0;
  logic                       rst_n                = 1'b0;
  logic                       cfg_we               = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index            = '0;
  logic [CFG_DATA_W-1:0]      cfg_data             = '0;
  logic                       in_valid             = 1'b0;
  logic                       in_stall;
  logic                       in_req_type          = REQ_WEIGHT;
  logic [TAP_FIELD_W-1:0]     in_weight_tap        = '0;
  logic [WIC_FIELD_W-1:0]     in_weight_in_channel = '0;
  logic [WOC_FIELD_W-1:0]     in_weight_out_channel = '0;
  logic signed [VAL_W-1:0]    in_value             = '0;
  logic                       in_sequence_start    = 1'b0;
  logic                       out_valid;
  logic                       out_stall            = 1'b0;
  logic [OUT_CH_W-1:0]        out_channel;
  logic signed [RES_W-1:0]    out_result_value;
  logic                       out_last;

  logic signed [VAL_W-1:0] krn_mem     [KRN_DEPTH];
  bit                      krn_written [KRN_DEPTH];
  logic signed [VAL_W-1:0] win_mem     [WIN_DEPTH];
  int unsigned             win_head;
  int unsigned             chan_pos;
  int unsigned             steps_seen;
  logic [CFG_TAPS_W-1:0]   taps_reg;
  logic [CFG_ICS_W-1:0]    ics_reg;
  logic [CFG_OCS_W-1:0]    ocs_reg;

  conv_out_t  pending_sums[$];
  int         mismatches = 0;
  idle_mode_e idle_mode  = IDLE_NONE;

  int unsigned ph_taps [6] = '{1, 3, 16, 2, 31, 3};
  int unsigned ph_ics  [6] = '{1, 2, 1, 8, 0, 15};
  int unsigned ph_ocs  [6] = '{1, 4, 2, 3, 0, 2};
  int unsigned ph_beats[6] = '{20, 25, 40, 35, 20, 50};

  conv1d_valid_multichannel uut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_req_type          (in_req_type),
    .in_weight_tap        (in_weight_tap),
    .in_weight_in_channel (in_weight_in_channel),
    .in_weight_out_channel(in_weight_out_channel),
    .in_value             (in_value),
    .in_sequence_start    (in_sequence_start),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_channel          (out_channel),
    .out_result_value     (out_result_value),
    .out_last             (out_last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int unsigned clamp_count(int unsigned raw, int unsigned hi);
    if (raw < 1) return 1;
    if (raw > hi) return hi;
    return raw;
  endfunction

  function automatic int unsigned krn_addr(int unsigned t, int unsigned ic, int unsigned oc);
    return (t * ICH_MAX + ic) * OCH_MAX + oc;
  endfunction

  function automatic void predict_conv_outputs(input beat_t b);
    int unsigned taps, ics, ocs, slot;
    longint      acc;
    conv_out_t   r;
    taps = clamp_count(taps_reg, TAPS_MAX);
    ics  = clamp_count(ics_reg, ICH_MAX);
    ocs  = clamp_count(ocs_reg, OCH_MAX);
    if (b.req_type == REQ_WEIGHT) begin
      krn_mem[krn_addr(b.tap, b.wic, b.woc)]     = b.value;
      krn_written[krn_addr(b.tap, b.wic, b.woc)] = 1'b1;
      return;
    end
    if (b.start) begin
      chan_pos   = 0;
      steps_seen = 0;
    end
    win_mem[win_head * ICH_MAX + chan_pos] = b.value;
    if (chan_pos + 1 < ics) begin
      chan_pos++;
      return;
    end
    chan_pos = 0;
    win_head = (win_head + 1) % TAPS_MAX;
    if (steps_seen < TAPS_MAX) steps_seen++;
    if (steps_seen < taps) return;
    for (int unsigned oc = 0; oc < ocs; oc++) begin
      acc = 0;
      for (int unsigned t = 0; t < taps; t++) begin
        slot = (win_head + TAPS_MAX - taps + t) % TAPS_MAX;
        for (int unsigned ic = 0; ic < ics; ic++)
          acc += longint'(win_mem[slot * ICH_MAX + ic]) * longint'(krn_mem[krn_addr(t, ic, oc)]);
      end
      r.channel = OUT_CH_W'(oc);
      r.total   = acc[RES_W-1:0];
      r.last    = (oc + 1 == ocs);
      pending_sums.push_back(r);
    end
  endfunction

  function automatic logic signed [VAL_W-1:0] rand_value();
    case ($urandom_range(0, 15))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return '0;
      default: return VAL_W'($urandom);
    endcase
  endfunction

  function automatic beat_t rand_beat();
    beat_t       b;
    int unsigned span;
    span       = 4 * clamp_count(taps_reg, TAPS_MAX) * clamp_count(ics_reg, ICH_MAX);
    b.req_type = ($urandom_range(0, 99) < 12) ? REQ_WEIGHT : REQ_SAMPLE;
    b.tap      = TAP_FIELD_W'($urandom);
    b.wic      = WIC_FIELD_W'($urandom);
    b.woc      = WOC_FIELD_W'($urandom);
    b.value    = rand_value();
    if (b.req_type == REQ_WEIGHT) b.start = 1'($urandom);
    else b.start = ($urandom_range(0, span) == 0);
    return b;
  endfunction

  function automatic dir_row_t weight_row(int unsigned t, int unsigned ic, int unsigned oc,
                                          logic [VAL_W-1:0] v, logic s);
    dir_row_t r;
    r.kind          = ROW_BEAT;
    r.beat.req_type = REQ_WEIGHT;
    r.beat.tap      = TAP_FIELD_W'(t);
    r.beat.wic      = WIC_FIELD_W'(ic);
    r.beat.woc      = WOC_FIELD_W'(oc);
    r.beat.value    = v;
    r.beat.start    = s;
    r.has_total     = 1'b0;
    return r;
  endfunction

  function automatic dir_row_t sample_row(logic [VAL_W-1:0] v, logic s, bit has,
                                          logic signed [RES_W-1:0] total);
    dir_row_t r;
    r.kind          = ROW_BEAT;
    r.beat.req_type = REQ_SAMPLE;
    r.beat.tap      = '0;
    r.beat.wic      = '0;
    r.beat.woc      = '0;
    r.beat.value    = v;
    r.beat.start    = s;
    r.has_total     = has;
    r.total         = total;
    return r;
  endfunction

  function automatic dir_row_t reg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    dir_row_t r;
    r.kind      = ROW_REG;
    r.reg_idx   = idx;
    r.reg_val   = val;
    r.has_total = 1'b0;
    return r;
  endfunction

  task automatic put_beat(input beat_t b);
    int unsigned gap_pct;
    gap_pct = (idle_mode == IDLE_SEND) ? 55 : (idle_mode == IDLE_BOTH) ? 26 : 0;
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid              <= 1'b1;
    in_req_type           <= b.req_type;
    in_weight_tap         <= b.tap;
    in_weight_in_channel  <= b.wic;
    in_weight_out_channel <= b.woc;
    in_value              <= b.value;
    in_sequence_start     <= b.start;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_conv_outputs(b);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    in_valid <= 1'b0;
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_FILTER_TAPS:  taps_reg = val[CFG_TAPS_W-1:0];
      CFG_IN_CHANNELS:  ics_reg  = val[CFG_ICS_W-1:0];
      CFG_OUT_CHANNELS: ocs_reg  = val[CFG_OCS_W-1:0];
      default: ;
    endcase
  endtask

  // load every kernel entry that the current setting can read
  task automatic fill_kernel();
    beat_t b;
    for (int unsigned t = 0; t < clamp_count(taps_reg, TAPS_MAX); t++)
      for (int unsigned ic = 0; ic < clamp_count(ics_reg, ICH_MAX); ic++)
        for (int unsigned oc = 0; oc < clamp_count(ocs_reg, OCH_MAX); oc++)
          if (!krn_written[krn_addr(t, ic, oc)]) begin
            b.req_type = REQ_WEIGHT;
            b.tap      = TAP_FIELD_W'(t);
            b.wic      = WIC_FIELD_W'(ic);
            b.woc      = WOC_FIELD_W'(oc);
            b.value    = rand_value();
            b.start    = 1'($urandom);
            put_beat(b);
          end
  endtask

  always @(posedge clk) begin
    int unsigned stall_pct;
    stall_pct = (idle_mode == IDLE_RECV) ? 55 : (idle_mode == IDLE_BOTH) ? 26 : 0;
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk) begin
    conv_out_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_sums.size() == 0) begin
        $error("unexpected result beat: out_channel %0d out_result_value %0d",
               out_channel, out_result_value);
        mismatches++;
      end else begin
        e = pending_sums.pop_front();
        if (out_channel !== e.channel) begin
          $error("out_channel: expected %0d, got %0d", e.channel, out_channel);
          mismatches++;
        end
        if (out_result_value !== e.total) begin
          $error("out_result_value: expected %0d, got %0d", e.total, out_result_value);
          mismatches++;
        end
        if (out_last !== e.last) begin
          $error("out_last: expected %0d, got %0d", e.last, out_last);
          mismatches++;
        end
      end
    end
  end

  initial begin
    dir_row_t    rows[$];
    conv_out_t   r;
    int unsigned n_beats;
    for (int i = 0; i < WIN_DEPTH; i++) win_mem[i] = '0;
    for (int i = 0; i < KRN_DEPTH; i++) begin
      krn_mem[i]     = '0;
      krn_written[i] = 1'b0;
    end
    win_head   = 0;
    chan_pos   = 0;
    steps_seen = 0;
    taps_reg   = 1;
    ics_reg    = 1;
    ocs_reg    = 1;

    rows.push_back(weight_row(0, 0, 0, 16'h7FFF, 1'b1));
    rows.push_back(sample_row(16'h7FFF, 1'b1, 1'b1, 39'sd1073676289));
    rows.push_back(sample_row(16'h8000, 1'b0, 1'b1, -39'sd1073709056));
    rows.push_back(weight_row(0, 0, 0, 16'h8000, 1'b0));
    rows.push_back(sample_row(16'h8000, 1'b0, 1'b1, 39'sd1073741824));
    rows.push_back(sample_row(16'h0000, 1'b0, 1'b1, '0));
    rows.push_back(reg_row(CFG_IN_CHANNELS, 5'd4));
    rows.push_back(sample_row(16'h1234, 1'b1, 1'b0, '0));
    rows.push_back(sample_row(16'hFEDC, 1'b0, 1'b0, '0));
    rows.push_back(sample_row(16'h7FFF, 1'b0, 1'b0, '0));
    rows.push_back(reg_row(CFG_IN_CHANNELS, 5'd2));
    rows.push_back(sample_row(16'h8001, 1'b0, 1'b0, '0));
    rows.push_back(reg_row(CFG_FILTER_TAPS, 5'd0));
    rows.push_back(reg_row(CFG_IN_CHANNELS, 5'd0));
    rows.push_back(reg_row(CFG_OUT_CHANNELS, 5'd31));
    rows.push_back(sample_row(16'h7FFF, 1'b0, 1'b0, '0));
    rows.push_back(reg_row(CFG_FILTER_TAPS, 5'd2));
    rows.push_back(reg_row(CFG_IN_CHANNELS, 5'd2));
    rows.push_back(reg_row(CFG_OUT_CHANNELS, 5'd2));
    rows.push_back(sample_row(16'h0100, 1'b1, 1'b0, '0));
    rows.push_back(sample_row(16'hFF00, 1'b0, 1'b0, '0));
    rows.push_back(sample_row(16'h8000, 1'b0, 1'b0, '0));
    rows.push_back(sample_row(16'h7FFF, 1'b0, 1'b0, '0));
    rows.push_back(sample_row(16'h0A5A, 1'b1, 1'b0, '0));
    rows.push_back(sample_row(16'hA5A5, 1'b0, 1'b0, '0));
    rows.push_back(sample_row(16'h5555, 1'b0, 1'b0, '0));
    rows.push_back(sample_row(16'hAAAA, 1'b0, 1'b0, '0));
    rows.push_back(weight_row(15, 7, 15, 16'h8000, 1'b1));
    rows.push_back(weight_row(15, 7, 15, 16'h7FFF, 1'b0));

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_REG) begin
        write_reg(rows[i].reg_idx, rows[i].reg_val);
        fill_kernel();
      end else begin
        put_beat(rows[i].beat);
        if (rows[i].has_total && pending_sums.size() != 0) begin
          r       = pending_sums.pop_back();
          r.total = rows[i].total;
          pending_sums.push_back(r);
        end
      end
    end

    for (int p = 0; p < N_PHASES; p++) begin
      if (p < 6) begin
        write_reg(CFG_FILTER_TAPS, CFG_DATA_W'(ph_taps[p]));
        write_reg(CFG_IN_CHANNELS, CFG_DATA_W'(ph_ics[p]));
        write_reg(CFG_OUT_CHANNELS, CFG_DATA_W'(ph_ocs[p]));
        n_beats = ph_beats[p];
      end else begin
        write_reg(CFG_FILTER_TAPS, CFG_DATA_W'($urandom_range(0, 4)));
        write_reg(CFG_IN_CHANNELS, CFG_DATA_W'($urandom_range(0, 3)));
        write_reg(CFG_OUT_CHANNELS, CFG_DATA_W'($urandom_range(0, 4)));
        n_beats = 15;
      end
      fill_kernel();
      idle_mode = idle_mode_e'(p % 4);
      repeat (n_beats) put_beat(rand_beat());
    end

    in_valid <= 1'b0;
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  initial begin
    #8_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
